// ===== src/cau_pkg.sv =====
package cau_pkg;

    localparam int WORD         = 32;
    localparam int FRAC         = 16;
    localparam int GUARD        = 2;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 33;
    localparam int DIV_FRAC     = FRAC + 1;
    localparam int QW           = DIV_STEPS;
    localparam int REM_W        = 97;
    localparam int CW           = 38;
    localparam int ZW           = 34;
    localparam int ANGLE_BITS   = 30;
    localparam int ANG_SHIFT    = ANGLE_BITS - FRAC;
    localparam int GAIN_SHIFT   = 28 + GUARD;

    localparam logic [WORD-1:0] MAX_WORD = {1'b0, {(WORD-1){1'b1}}};
    localparam logic [WORD-1:0] MIN_WORD = {1'b1, {(WORD-1){1'b0}}};
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
    localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< (FRAC - 1);
    localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;

    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_SCALE = 4'd4,
        OP_SDIV  = 4'd5,
        OP_CONJ  = 4'd6,
        OP_MAG   = 4'd7,
        OP_ARG   = 4'd8
    } op_t;

    typedef struct packed {
        logic [3:0]             operation;
        logic signed [WORD-1:0] a_re;
        logic signed [WORD-1:0] a_im;
        logic signed [WORD-1:0] b_re;
        logic signed [WORD-1:0] b_im;
    } operand_t;

    typedef struct packed {
        logic signed [WORD-1:0] r_re;
        logic signed [WORD-1:0] r_im;
        logic                   overflow;
        logic                   divide_by_zero;
    } result_t;

    typedef struct packed {
        logic [WORD-1:0] val;
        logic            ovf;
    } sat_t;

    typedef struct packed {
        logic [3:0]           op;
        logic [WORD-1:0]      s_re;
        logic [WORD-1:0]      s_im;
        logic                 s_ovf;
        logic                 neg_re;
        logic                 neg_im;
        logic                 zero_re;
        logic                 zero_im;
        logic                 den_zero;
        logic [63:0]          den;
        logic [REM_W-1:0]     rem_re;
        logic [REM_W-1:0]     rem_im;
        logic [QW-1:0]        quo_re;
        logic [QW-1:0]        quo_im;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] cz;
        logic                 nonzero;
    } cau_work_t;

    function automatic sat_t sat_word(input logic signed [65:0] v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.val = MAX_WORD;
            r.ovf = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            r.val = MIN_WORD;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[WORD-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [63:0] inv_gain_calc();
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        int i;
        p = 64'd1 << 60;
        for (i = 0; i < CORDIC_STEPS; i++)
            p = p + (p >> (2 * i));
        v = p;
        res = '0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++)
            if (b > v)
                b = b >> 2;
        for (i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
        end
        num = 64'd1 << 58;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= res)
            begin
                rem = rem - res;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    localparam logic [27:0] INV_GAIN = 28'(inv_gain_calc());

endpackage

// ===== src/cau_front.sv =====
module cau_front
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  operand_t  in_data,
    output logic      out_valid,
    output cau_work_t out_data
);

    typedef struct packed {
        logic [3:0]             op;
        logic signed [WORD-1:0] a_re;
        logic signed [WORD-1:0] a_im;
        logic signed [WORD-1:0] b_re;
        logic signed [WORD-1:0] b_im;
        logic signed [63:0]     p_rr;
        logic signed [63:0]     p_ii;
        logic signed [63:0]     p_ri;
        logic signed [63:0]     p_ir;
        logic signed [63:0]     p_br2;
        logic signed [63:0]     p_bi2;
    } prod_t;

    operand_t  in_reg;
    logic      in_valid_reg;
    prod_t     prod_reg;
    prod_t     prod_next;
    logic      prod_valid_reg;
    cau_work_t work_reg;
    cau_work_t work_next;
    logic      work_valid_reg;

    logic signed [65:0]   t_mre;
    logic signed [65:0]   t_mim;
    logic signed [65:0]   t_scr;
    logic signed [65:0]   t_sci;
    logic signed [65:0]   d_sre;
    logic signed [65:0]   d_sim;
    logic [63:0]          m_sre;
    logic [63:0]          m_sim;
    logic [63:0]          den3;
    logic [WORD:0]        abs_ar;
    logic [WORD:0]        abs_ai;
    logic [WORD:0]        abs_br;
    logic [63:0]          num_re;
    logic [63:0]          num_im;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    sat_t                 sr;
    sat_t                 si;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            work_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg   <= in_valid;
            prod_valid_reg <= in_valid_reg;
            work_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg   <= in_data;
            prod_reg <= prod_next;
            work_reg <= work_next;
        end
    end

    always_comb
    begin
        prod_next.op    = in_reg.operation;
        prod_next.a_re  = in_reg.a_re;
        prod_next.a_im  = in_reg.a_im;
        prod_next.b_re  = in_reg.b_re;
        prod_next.b_im  = in_reg.b_im;
        prod_next.p_rr  = 64'(in_reg.a_re) * 64'(in_reg.b_re);
        prod_next.p_ii  = 64'(in_reg.a_im) * 64'(in_reg.b_im);
        prod_next.p_ri  = 64'(in_reg.a_re) * 64'(in_reg.b_im);
        prod_next.p_ir  = 64'(in_reg.a_im) * 64'(in_reg.b_re);
        prod_next.p_br2 = 64'(in_reg.b_re) * 64'(in_reg.b_re);
        prod_next.p_bi2 = 64'(in_reg.b_im) * 64'(in_reg.b_im);
    end

    always_comb
    begin
        t_mre = (66'(prod_reg.p_rr) - 66'(prod_reg.p_ii) + ROUND_HALF) >>> FRAC;
        t_mim = (66'(prod_reg.p_ri) + 66'(prod_reg.p_ir) + ROUND_HALF) >>> FRAC;
        t_scr = (66'(prod_reg.p_rr) + ROUND_HALF) >>> FRAC;
        t_sci = (66'(prod_reg.p_ir) + ROUND_HALF) >>> FRAC;

        case (prod_reg.op)
            OP_ADD:
            begin
                sr = sat_word(66'(prod_reg.a_re) + 66'(prod_reg.b_re));
                si = sat_word(66'(prod_reg.a_im) + 66'(prod_reg.b_im));
            end
            OP_SUB:
            begin
                sr = sat_word(66'(prod_reg.a_re) - 66'(prod_reg.b_re));
                si = sat_word(66'(prod_reg.a_im) - 66'(prod_reg.b_im));
            end
            OP_MUL:
            begin
                sr = sat_word(t_mre);
                si = sat_word(t_mim);
            end
            OP_SCALE:
            begin
                sr = sat_word(t_scr);
                si = sat_word(t_sci);
            end
            OP_CONJ:
            begin
                sr.val = prod_reg.a_re;
                sr.ovf = 1'b0;
                si = sat_word(-66'(prod_reg.a_im));
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase

        d_sre = 66'(prod_reg.p_rr) + 66'(prod_reg.p_ii);
        d_sim = 66'(prod_reg.p_ir) - 66'(prod_reg.p_ri);
        m_sre = d_sre[65] ? 64'(-d_sre) : 64'(d_sre);
        m_sim = d_sim[65] ? 64'(-d_sim) : 64'(d_sim);
        den3  = 64'(prod_reg.p_br2) + 64'(prod_reg.p_bi2);
        abs_ar = prod_reg.a_re[WORD-1] ? ((WORD+1)'(0) - (WORD+1)'(prod_reg.a_re))
                                       : (WORD+1)'(prod_reg.a_re);
        abs_ai = prod_reg.a_im[WORD-1] ? ((WORD+1)'(0) - (WORD+1)'(prod_reg.a_im))
                                       : (WORD+1)'(prod_reg.a_im);
        abs_br = prod_reg.b_re[WORD-1] ? ((WORD+1)'(0) - (WORD+1)'(prod_reg.b_re))
                                       : (WORD+1)'(prod_reg.b_re);

        work_next.op    = prod_reg.op;
        work_next.s_re  = sr.val;
        work_next.s_im  = si.val;
        work_next.s_ovf = sr.ovf | si.ovf;

        if (prod_reg.op == OP_DIV)
        begin
            num_re           = m_sre;
            num_im           = m_sim;
            work_next.neg_re = d_sre[65];
            work_next.neg_im = d_sim[65];
            work_next.den    = den3;
        end
        else
        begin
            num_re           = 64'(abs_ar);
            num_im           = 64'(abs_ai);
            work_next.neg_re = prod_reg.a_re[WORD-1] ^ prod_reg.b_re[WORD-1];
            work_next.neg_im = prod_reg.a_im[WORD-1] ^ prod_reg.b_re[WORD-1];
            work_next.den    = 64'(abs_br);
        end
        work_next.zero_re  = (num_re == '0);
        work_next.zero_im  = (num_im == '0);
        work_next.den_zero = (work_next.den == '0);
        work_next.rem_re   = REM_W'(num_re) << DIV_FRAC;
        work_next.rem_im   = REM_W'(num_im) << DIV_FRAC;
        work_next.quo_re   = '0;
        work_next.quo_im   = '0;

        x0 = CW'(prod_reg.a_re) <<< GUARD;
        y0 = CW'(prod_reg.a_im) <<< GUARD;
        if (x0[CW-1])
        begin
            if (!y0[CW-1])
            begin
                work_next.cx = y0;
                work_next.cy = -x0;
                work_next.cz = HALF_PI;
            end
            else
            begin
                work_next.cx = -y0;
                work_next.cy = x0;
                work_next.cz = -HALF_PI;
            end
        end
        else
        begin
            work_next.cx = x0;
            work_next.cy = y0;
            work_next.cz = '0;
        end
        work_next.nonzero = (prod_reg.a_re != '0) || (prod_reg.a_im != '0);
    end

    assign out_valid = work_valid_reg;
    assign out_data  = work_reg;

endmodule

// ===== src/cau_core.sv =====
module cau_core
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cau_work_t in_data,
    output logic      out_valid,
    output cau_work_t out_data
);

    cau_work_t chain      [DIV_STEPS+1];
    logic      chain_vld  [DIV_STEPS+1];
    cau_work_t stage_reg  [DIV_STEPS];
    cau_work_t stage_next [DIV_STEPS];
    logic      valid_reg  [DIV_STEPS];

    assign chain[0]     = in_data;
    assign chain_vld[0] = in_valid;

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_stage
        localparam int J = DIV_STEPS - 1 - s;

        always_comb
        begin
            stage_next[s] = chain[s];
            if (chain[s].rem_re >= (REM_W'(chain[s].den) << J))
            begin
                stage_next[s].rem_re    = chain[s].rem_re - (REM_W'(chain[s].den) << J);
                stage_next[s].quo_re[J] = 1'b1;
            end
            if (chain[s].rem_im >= (REM_W'(chain[s].den) << J))
            begin
                stage_next[s].rem_im    = chain[s].rem_im - (REM_W'(chain[s].den) << J);
                stage_next[s].quo_im[J] = 1'b1;
            end
            if (s < CORDIC_STEPS)
            begin
                if (!chain[s].cy[CW-1])
                begin
                    stage_next[s].cx = chain[s].cx + (chain[s].cy >>> s);
                    stage_next[s].cy = chain[s].cy - (chain[s].cx >>> s);
                    stage_next[s].cz = chain[s].cz + ZW'(ATAN_TABLE[s]);
                end
                else
                begin
                    stage_next[s].cx = chain[s].cx - (chain[s].cy >>> s);
                    stage_next[s].cy = chain[s].cy + (chain[s].cx >>> s);
                    stage_next[s].cz = chain[s].cz - ZW'(ATAN_TABLE[s]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= chain_vld[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stage_reg[s] <= stage_next[s];
        end

        assign chain[s+1]     = stage_reg[s];
        assign chain_vld[s+1] = valid_reg[s];
    end

    assign out_valid = chain_vld[DIV_STEPS];
    assign out_data  = chain[DIV_STEPS];

endmodule

// ===== src/cau_back.sv =====
module cau_back
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cau_work_t in_data,
    output logic      out_valid,
    output result_t   out_data
);

    typedef struct packed {
        logic [3:0]      op;
        logic [WORD-1:0] s_re;
        logic [WORD-1:0] s_im;
        logic            s_ovf;
        logic [WORD-1:0] d_re;
        logic [WORD-1:0] d_im;
        logic            d_ovf;
        logic            dz;
        logic [64:0]     mag_prod;
        logic [WORD-1:0] ang;
        logic            ang_ovf;
    } fin_t;

    fin_t    fin_reg;
    fin_t    fin_next;
    logic    fin_valid_reg;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;

    sat_t               dre;
    sat_t               dim;
    sat_t               as;
    logic               wide_re;
    logic               wide_im;
    logic signed [34:0] t_ang;
    logic [64:0]        mag;
    logic [WORD-1:0]    mag_val;
    logic               mag_ovf;

    // wide: the quotient did not fit the quotient register, so the result saturates
    function automatic sat_t div_result(input logic [QW-1:0] quo, input logic neg,
                                        input logic zero, input logic den_zero,
                                        input logic wide);
        logic [QW:0] q;
        logic [QW:0] lim;
        logic [QW:0] qn;
        sat_t r;
        q   = ({1'b0, quo} + (QW+1)'(1)) >> 1;
        lim = ((QW+1)'(1) << (WORD - 1)) - (neg ? (QW+1)'(0) : (QW+1)'(1));
        r.ovf = (q > lim) || wide;
        if (r.ovf)
            q = lim;
        qn = neg ? (~q + (QW+1)'(1)) : q;
        r.val = qn[WORD-1:0];
        if (den_zero)
        begin
            r.ovf = 1'b0;
            r.val = zero ? '0 : (neg ? MIN_WORD : MAX_WORD);
        end
        return r;
    endfunction

    always_comb
    begin
        wide_re = (in_data.rem_re >= REM_W'(in_data.den));
        wide_im = (in_data.rem_im >= REM_W'(in_data.den));
        dre = div_result(in_data.quo_re, in_data.neg_re, in_data.zero_re, in_data.den_zero,
                         wide_re);
        dim = div_result(in_data.quo_im, in_data.neg_im, in_data.zero_im, in_data.den_zero,
                         wide_im);
        t_ang = (35'(in_data.cz) + (35'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
        as = sat_word(66'(t_ang));
        if (!in_data.nonzero)
            as = '0;

        fin_next.op       = in_data.op;
        fin_next.s_re     = in_data.s_re;
        fin_next.s_im     = in_data.s_im;
        fin_next.s_ovf    = in_data.s_ovf;
        fin_next.d_re     = dre.val;
        fin_next.d_im     = dim.val;
        fin_next.d_ovf    = dre.ovf | dim.ovf;
        fin_next.dz       = in_data.den_zero;
        fin_next.mag_prod = 65'(in_data.cx[CW-2:0]) * 65'(INV_GAIN);
        fin_next.ang      = as.val;
        fin_next.ang_ovf  = as.ovf;
    end

    always_comb
    begin
        mag = (fin_reg.mag_prod + (65'd1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
        mag_ovf = (mag > 65'(MAX_WORD));
        mag_val = mag_ovf ? MAX_WORD : mag[WORD-1:0];

        out_next = '0;
        case (fin_reg.op)
            OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_CONJ:
            begin
                out_next.r_re     = fin_reg.s_re;
                out_next.r_im     = fin_reg.s_im;
                out_next.overflow = fin_reg.s_ovf;
            end
            OP_DIV, OP_SDIV:
            begin
                out_next.r_re           = fin_reg.d_re;
                out_next.r_im           = fin_reg.d_im;
                out_next.overflow       = fin_reg.d_ovf;
                out_next.divide_by_zero = fin_reg.dz;
            end
            OP_MAG:
            begin
                out_next.r_re     = mag_val;
                out_next.overflow = mag_ovf;
            end
            OP_ARG:
            begin
                out_next.r_re     = fin_reg.ang;
                out_next.overflow = fin_reg.ang_ovf;
            end
            default:
                out_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= in_valid;
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= fin_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Every operation has the same latency from operand transfer to result valid.
// Throughput: one item per cycle; the 33-stage quotient pipeline, in parallel with
// the 16 CORDIC stages, sets the depth, and every stage advances while the output is free.
// A one-entry skid register takes an operand while a finished result is held.
// Reset (rst_n low, asynchronous) clears all valid bits and the skid; data is not reset.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     operand_valid,
    output logic     operand_ready,
    input  operand_t operand,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    operand_t  skid_reg;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    logic      en;
    logic      pipe_valid;
    operand_t  pipe_data;
    logic      front_valid;
    cau_work_t front_data;
    logic      core_valid;
    cau_work_t core_data;

    assign en            = !result_valid || result_ready;
    assign operand_ready = !skid_valid_reg;
    assign pipe_valid    = skid_valid_reg || operand_valid;
    assign pipe_data     = skid_valid_reg ? skid_reg : operand;

    always_comb
    begin
        if (skid_valid_reg)
            skid_valid_next = !en;
        else
            skid_valid_next = operand_valid && !en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    // hold a transfer that arrives while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && !en)
            skid_reg <= operand;
    end

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pipe_valid),
        .in_data   (pipe_data),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    cau_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (core_valid),
        .out_data  (core_data)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (core_valid),
        .in_data   (core_data),
        .out_valid (result_valid),
        .out_data  (result)
    );

`ifndef SYNTHESIS
    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_by_zero |-> !result.overflow)
        else $error("divide by zero reported with overflow");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !en |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost during stall");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        operand_valid && operand_ready && !en |=> skid_valid_reg)
        else $error("stalled transfer not captured");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import cau_pkg::*;

    localparam logic [3:0] OP_SPARE_LO = 4'd9;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint QUARTER_TURN = 64'sd1686629713;
    localparam int RANDOM_ITEMS = 450;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        operand_t op;
        bit       known;
        result_t  res;
    } row_t;

    logic     clk;
    logic     rst_n;
    logic     operand_valid;
    logic     operand_ready;
    operand_t operand;
    logic     result_valid;
    logic     result_ready;
    result_t  result;

    result_t  pending_results[$];
    row_t     rows[$];
    int       errors;
    int       idle_cycles;
    bit       quiet;
    bit       rx_hold;
    longint unsigned gain_recip;

    complex_arithmetic_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_ready (operand_ready),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] clip(longint v, inout logic ovf);
        if (v > WMAX)
        begin
            ovf = 1'b1;
            return MAX_WORD;
        end
        if (v < WMIN)
        begin
            ovf = 1'b1;
            return MIN_WORD;
        end
        return v[31:0];
    endfunction

    function automatic bit sum_sign_mag(longint p1, longint p2, output longint unsigned mag);
        longint unsigned m1;
        longint unsigned m2;
        m1 = p1 < 0 ? longint'(-p1) : p1;
        m2 = p2 < 0 ? longint'(-p2) : p2;
        if ((p1 < 0) == (p2 < 0))
        begin
            mag = m1 + m2;
            return p1 < 0;
        end
        if (p1 < 0)
        begin
            m1 = m2;
            m2 = p1 < 0 ? longint'(-p1) : p1;
        end
        if (m1 >= m2)
        begin
            mag = m1 - m2;
            return 1'b0;
        end
        mag = m2 - m1;
        return 1'b1;
    endfunction

    function automatic longint quotient(longint unsigned num, longint unsigned den, bit neg,
                                        inout logic ovf, inout logic dz);
        longint unsigned lim;
        longint unsigned q;
        longint unsigned rem;
        lim = 64'd1 << 31;
        if (den == 0)
        begin
            dz = 1'b1;
            if (num == 0)
                return 0;
            return neg ? WMIN : WMAX;
        end
        if (!neg)
            lim = lim - 1;
        q = num / den;
        rem = num % den;
        if (q > (lim >> FRAC))
        begin
            ovf = 1'b1;
            return neg ? WMIN : WMAX;
        end
        for (int k = 0; k < FRAC; k++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                q = q | 1;
                rem = rem - den;
            end
        end
        rem = rem << 1;
        if (rem >= den)
            q = q + 1;
        if (q > lim)
        begin
            ovf = 1'b1;
            q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned cordic_gain_recip();
        longint unsigned p;
        longint unsigned v;
        longint unsigned root;
        longint unsigned b;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STEPS; i++)
            p = p + (p >> (2 * i));
        v = p;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return (64'd1 << 58) / root;
    endfunction

    function automatic void vectoring(longint re, longint im, output longint xo, output longint zo);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = re * 4;
        y = im * 4;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TABLE[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TABLE[i]);
            end
        end
        xo = x;
        zo = z;
    endfunction

    function automatic result_t complex_result(operand_t x);
        result_t r;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint cx;
        longint cz;
        longint unsigned mag;
        longint unsigned den;
        bit neg;
        logic ovf;
        logic dz;
        ar = longint'($signed(x.a_re));
        ai = longint'($signed(x.a_im));
        br = longint'($signed(x.b_re));
        bi = longint'($signed(x.b_im));
        ovf = 1'b0;
        dz = 1'b0;
        r = '0;
        case (x.operation)
            OP_ADD:
            begin
                r.r_re = clip(ar + br, ovf);
                r.r_im = clip(ai + bi, ovf);
            end
            OP_SUB:
            begin
                r.r_re = clip(ar - br, ovf);
                r.r_im = clip(ai - bi, ovf);
            end
            OP_MUL:
            begin
                r.r_re = clip(((ar * br) >>> FRAC) + ((-(ai * bi)) >>> FRAC)
                    + longint'((((ar * br) & 64'hFFFF) + ((-(ai * bi)) & 64'hFFFF)
                    + 64'h8000) >> FRAC), ovf);
                r.r_im = clip(((ar * bi) >>> FRAC) + ((ai * br) >>> FRAC)
                    + longint'((((ar * bi) & 64'hFFFF) + ((ai * br) & 64'hFFFF)
                    + 64'h8000) >> FRAC), ovf);
            end
            OP_DIV:
            begin
                den = longint'(br * br) + longint'(bi * bi);
                neg = sum_sign_mag(ar * br, ai * bi, mag);
                r.r_re = 32'(quotient(mag, den, neg, ovf, dz));
                neg = sum_sign_mag(ai * br, -(ar * bi), mag);
                r.r_im = 32'(quotient(mag, den, neg, ovf, dz));
            end
            OP_SCALE:
            begin
                r.r_re = clip((ar * br + 64'sd32768) >>> FRAC, ovf);
                r.r_im = clip((ai * br + 64'sd32768) >>> FRAC, ovf);
            end
            OP_SDIV:
            begin
                den = br < 0 ? -br : br;
                r.r_re = 32'(quotient(ar < 0 ? -ar : ar, den, (ar < 0) != (br < 0), ovf, dz));
                r.r_im = 32'(quotient(ai < 0 ? -ai : ai, den, (ai < 0) != (br < 0), ovf, dz));
            end
            OP_CONJ:
            begin
                r.r_re = x.a_re;
                r.r_im = clip(-ai, ovf);
            end
            OP_MAG:
            begin
                vectoring(ar, ai, cx, cz);
                mag = (longint'(cx) * gain_recip + (64'd1 << 29)) >> 30;
                if (mag > WMAX)
                begin
                    ovf = 1'b1;
                    mag = WMAX;
                end
                r.r_re = mag[31:0];
            end
            OP_ARG:
            begin
                if (ar != 0 || ai != 0)
                begin
                    vectoring(ar, ai, cx, cz);
                    cz = (cz + (64'sd1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
                    r.r_re = clip(cz, ovf);
                end
            end
            default:
            begin
            end
        endcase
        r.overflow = ovf;
        r.divide_by_zero = dz;
        return r;
    endfunction

    task automatic add_row(logic [3:0] op, logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                           logic [31:0] bi, bit known, logic [31:0] er, logic [31:0] ei,
                           logic eo, logic ed);
        row_t w;
        w.op = '{operation: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
        w.known = known;
        w.res = '{r_re: er, r_im: ei, overflow: eo, divide_by_zero: ed};
        rows.push_back(w);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            2:
            begin
                case ($urandom_range(4))
                    0: return MAX_WORD;
                    1: return MIN_WORD;
                    2: return '0;
                    3: return ONE;
                    default: return NEG_ONE;
                endcase
            end
            3: return 32'($signed($urandom_range(200)) - 100) << FRAC;
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic transfer(operand_t x, bit known, result_t res);
        if (!quiet)
        begin
            while ($urandom_range(99) < 9)
            begin
                operand_valid <= 1'b0;
                @(posedge clk);
            end
        end
        operand_valid <= 1'b1;
        operand <= x;
        do
            @(posedge clk);
        while (!operand_ready);
        pending_results.push_back(known ? res : complex_result(x));
    endtask

    task automatic drain();
        operand_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
                result_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                if (result.r_re !== pending_results[0].r_re)
                begin
                    $display("%0t: r_re expected %h actual %h", $time,
                             pending_results[0].r_re, result.r_re);
                    errors++;
                end
                if (result.r_im !== pending_results[0].r_im)
                begin
                    $display("%0t: r_im expected %h actual %h", $time,
                             pending_results[0].r_im, result.r_im);
                    errors++;
                end
                if (result.overflow !== pending_results[0].overflow)
                begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             pending_results[0].overflow, result.overflow);
                    errors++;
                end
                if (result.divide_by_zero !== pending_results[0].divide_by_zero)
                begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             pending_results[0].divide_by_zero, result.divide_by_zero);
                    errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((operand_valid && operand_ready) || (result_valid && result_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        operand_t x;
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        rx_hold = 1'b0;
        gain_recip = cordic_gain_recip();
        rst_n <= 1'b0;
        operand_valid <= 1'b0;
        operand <= '0;

        add_row(OP_ADD, '0, '0, '0, '0, 1, '0, '0, 0, 0);
        add_row(OP_ADD, MAX_WORD, MAX_WORD, 32'd1, 32'd1, 1, MAX_WORD, MAX_WORD, 1, 0);
        add_row(OP_SUB, MIN_WORD, MIN_WORD, 32'd1, 32'd1, 1, MIN_WORD, MIN_WORD, 1, 0);
        add_row(OP_DIV, ONE, NEG_ONE, '0, '0, 1, '0, '0, 0, 1);
        add_row(OP_DIV, '0, '0, '0, '0, 1, '0, '0, 0, 1);
        add_row(OP_SDIV, NEG_ONE, '0, '0, MAX_WORD, 1, MIN_WORD, '0, 0, 1);
        add_row(OP_CONJ, ONE, MIN_WORD, MAX_WORD, MAX_WORD, 1, ONE, MAX_WORD, 1, 0);
        add_row(OP_ARG, '0, '0, MAX_WORD, MIN_WORD, 1, '0, '0, 0, 0);
        add_row(OP_MAG, '0, '0, '0, '0, 1, '0, '0, 0, 0);
        add_row(OP_SPARE_LO, MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD, 1, '0, '0, 0, 0);
        add_row(OP_SPARE_HI, MIN_WORD, MAX_WORD, ONE, NEG_ONE, 1, '0, '0, 0, 0);
        add_row(OP_ADD, 32'h1234_5678, NEG_ONE, 32'hFFFF_8000, ONE, 0, '0, '0, 0, 0);
        add_row(OP_MUL, ONE, ONE, ONE, NEG_ONE, 0, '0, '0, 0, 0);
        add_row(OP_MUL, MIN_WORD, MIN_WORD, MIN_WORD, MAX_WORD, 0, '0, '0, 0, 0);
        add_row(OP_MUL, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 0,
                '0, '0, 0, 0);
        add_row(OP_DIV, 32'h0003_0000, 32'h0004_0000, ONE, 32'h0002_0000, 0, '0, '0, 0, 0);
        add_row(OP_DIV, MAX_WORD, MIN_WORD, 32'h0000_0001, '0, 0, '0, '0, 0, 0);
        add_row(OP_SCALE, MIN_WORD, MAX_WORD, MIN_WORD, MAX_WORD, 0, '0, '0, 0, 0);
        add_row(OP_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, '0, 0, '0, '0, 0, 0);
        add_row(OP_SDIV, MIN_WORD, MAX_WORD, NEG_ONE, ONE, 0, '0, '0, 0, 0);
        add_row(OP_SDIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0003_0000, '0, 0, '0, '0, 0, 0);
        add_row(OP_CONJ, MIN_WORD, MAX_WORD, '0, '0, 0, '0, '0, 0, 0);
        add_row(OP_MAG, MIN_WORD, MIN_WORD, '0, '0, 0, '0, '0, 0, 0);
        add_row(OP_ARG, NEG_ONE, '0, '0, '0, 0, '0, '0, 0, 0);
        add_row(OP_ARG, NEG_ONE, 32'hFFFF_FFFF, '0, '0, 0, '0, '0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            transfer(rows[i].op, rows[i].known, rows[i].res);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 100 && n < 200);
            if (n == 250)
                rx_hold = 1'b1;
            if (n == 350)
                drain();
            x.operation = ($urandom_range(19) == 0) ? 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))
                                                    : 4'($urandom_range(OP_ARG, OP_ADD));
            x.a_re = pick_word();
            x.a_im = pick_word();
            x.b_re = pick_word();
            x.b_im = pick_word();
            transfer(x, 0, '0);
        end
        quiet = 1'b0;
        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/cau_pkg.sv
src/cau_front.sv
src/cau_core.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
sim/testbench.sv
